// ===== rtl/hbm_pkg.sv =====
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types, codes and reset values of the heap budget monitor.
// ----------------------------------------------------------------------------
package hbm_pkg;

  localparam int BYTE_BITS_DEF = 40;

  // Port widths fixed by the word format.
  localparam int AMT_W  = 40;
  localparam int FREE_W = 41;
  localparam int THR_W  = 16;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 40;

  typedef enum logic [1:0] {
    OP_ALLOC        = 2'd0,
    OP_FREE         = 2'd1,
    OP_ADVISE       = 2'd2,
    OP_ADVISE_LOCAL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ADV_OK       = 2'd0,
    ADV_CAUTIOUS = 2'd1,
    ADV_EVICT    = 2'd2,
    ADV_DENY     = 2'd3
  } advice_t;

  localparam logic [CIDX_W-1:0] CFG_BUDGET0   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BUDGET1   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_LOCAL_MSK = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HOST_MSK  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_WARN_THR  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CRIT_THR  = 3'd5;

  localparam logic [AMT_W-1:0] BUDGET0_RST = 40'd8589934592;
  localparam logic [AMT_W-1:0] BUDGET1_RST = 40'd17179869184;
  localparam logic [1:0]       LOCAL_RST   = 2'd1;
  localparam logic [THR_W-1:0] WARN_RST    = 16'd52429;
  localparam logic [THR_W-1:0] CRIT_RST    = 16'd62259;

endpackage

// ===== rtl/heap_budget_monitor.sv =====
// ----------------------------------------------------------------------------
// heap_budget_monitor
// Usage accounting and allocation advice for two memory heaps.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   opcode, heap_select, byte_amount
//  out_     output     out_valid/out_stall advice, usage_after, free bytes, flags
//  cfg_     input      cfg_valid/cfg_ready register index, data
//
//  One word per cycle sustained while the output is not stalled; the result
//  register loads a word from the input register once the output is free.
//  The usage read-modify-write sits between those registers, so each word sees
//  the usage left by the word before it.
//  Budget-times-threshold products are registered from the configuration
//  registers, so a write reaches them through one more register.
//  Synchronous active-low reset clears the usage counts, the pipeline valids
//  and restores the register reset values. A stalled output holds its word
//  and backs up into the input register, then into in_stall.
// ----------------------------------------------------------------------------
module heap_budget_monitor #(
  parameter int BYTE_BITS = hbm_pkg::BYTE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [1:0]                  in_heap_select,
  input  logic [hbm_pkg::AMT_W-1:0]   in_byte_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_advice,
  output logic [hbm_pkg::AMT_W-1:0]   out_usage_after,
  output logic [hbm_pkg::FREE_W-1:0]  out_free_device_local,
  output logic                        out_local_warning,
  output logic                        out_local_critical,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hbm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [hbm_pkg::CDAT_W-1:0]  cfg_data
);
  import hbm_pkg::*;

  localparam int BW = BYTE_BITS;
  // Budgets and amounts keep at most AMT_W bits.
  localparam int AW = (BW < AMT_W) ? BW : AMT_W;
  // Working width: holds a sum of two usages and a sum of two budgets.
  localparam int XW = BW + 2;
  localparam int PW = XW + THR_W;
  localparam logic [AMT_W:0]   ONE_EXT  = 1;
  localparam logic [AMT_W-1:0] BUD_MASK = AMT_W'((ONE_EXT << AW) - ONE_EXT);

  // Configuration.
  logic [AMT_W-1:0] budget_r [2];
  logic [1:0]       local_r;
  logic [THR_W-1:0] warn_r;
  logic [THR_W-1:0] crit_r;

  // Products of budget and threshold, rebuilt every cycle from the registers.
  logic [PW-1:0] prod_w_r [2];
  logic [PW-1:0] prod_c_r [2];
  logic [PW-1:0] agg_w_r;
  logic [PW-1:0] agg_c_r;
  logic          agg_zero_r;
  logic [XW-1:0] agg_budget;

  // Pipeline.
  logic             s1_valid_r;
  opcode_t          s1_op_r;
  logic [1:0]       s1_sel_r;
  logic [AMT_W-1:0] s1_amt_r;
  logic [BW-1:0]    usage_r   [2];
  logic [BW-1:0]    usage_nxt [2];

  logic          out_free;
  logic          s1_go;
  logic          in_take;

  logic [BW-1:0] amt;
  logic [BW-1:0] cur;
  logic [BW:0]   add_sum;
  logic [BW-1:0] upd;
  logic          adv_en;
  logic          adv_h;
  logic [BW:0]   proj;
  logic [XW-1:0] adv_budget;
  logic [PW-1:0] proj_sh;
  logic [XW-1:0] usum;
  logic [PW-1:0] usum_sh;
  logic [XW-1:0] free_sum;

  advice_t          advice_nxt;
  logic [AMT_W-1:0] used_nxt;
  logic [FREE_W-1:0] free_nxt;
  logic             warn_nxt;
  logic             crit_nxt;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign s1_go     = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r[0] <= BUDGET0_RST & BUD_MASK;
      budget_r[1] <= BUDGET1_RST & BUD_MASK;
      local_r     <= LOCAL_RST;
      warn_r      <= WARN_RST;
      crit_r      <= CRIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // The host-visible mask has no effect on any result and is not stored.
      unique case (cfg_index)
        CFG_BUDGET0:   budget_r[0] <= cfg_data & BUD_MASK;
        CFG_BUDGET1:   budget_r[1] <= cfg_data & BUD_MASK;
        CFG_LOCAL_MSK: local_r     <= cfg_data[1:0];
        CFG_HOST_MSK:  ;
        CFG_WARN_THR:  warn_r      <= cfg_data[THR_W-1:0];
        CFG_CRIT_THR:  crit_r      <= cfg_data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  assign agg_budget = (local_r[0] ? XW'(budget_r[0]) : '0) +
                      (local_r[1] ? XW'(budget_r[1]) : '0);

  always_ff @(posedge clk) begin
    for (int h = 0; h < 2; h++) begin
      prod_w_r[h] <= PW'(budget_r[h]) * PW'(warn_r);
      prod_c_r[h] <= PW'(budget_r[h]) * PW'(crit_r);
    end
    agg_w_r    <= PW'(agg_budget) * PW'(warn_r);
    agg_c_r    <= PW'(agg_budget) * PW'(crit_r);
    agg_zero_r <= (agg_budget == '0);
  end

  always_comb begin
    amt      = BW'(s1_amt_r & BUD_MASK);
    cur      = usage_r[s1_sel_r[0]];
    add_sum  = {1'b0, cur} + {1'b0, amt};
    usage_nxt = usage_r;
    advice_nxt = ADV_OK;
    used_nxt   = '0;
    adv_en     = 1'b0;
    adv_h      = 1'b0;

    if (s1_op_r == OP_ALLOC) begin
      upd = add_sum[BW] ? '1 : add_sum[BW-1:0];
    end else begin
      upd = (cur >= amt) ? cur - amt : '0;
    end

    case (s1_op_r) inside
      OP_ALLOC, OP_FREE: begin
        if (!s1_sel_r[1]) begin
          usage_nxt[s1_sel_r[0]] = upd;
          used_nxt = AMT_W'(upd);
        end
      end
      OP_ADVISE: begin
        if (!s1_sel_r[1]) begin
          adv_en = 1'b1;
          adv_h  = s1_sel_r[0];
        end else begin
          advice_nxt = ADV_DENY;
        end
      end
      default: begin
        // The first device-local heap, ignoring heap_select.
        if (local_r[0]) begin
          adv_en = 1'b1;
          adv_h  = 1'b0;
        end else if (local_r[1]) begin
          adv_en = 1'b1;
          adv_h  = 1'b1;
        end else begin
          advice_nxt = ADV_DENY;
        end
      end
    endcase

    proj       = {1'b0, usage_r[adv_h]} + {1'b0, amt};
    adv_budget = XW'(budget_r[adv_h]);
    proj_sh    = {XW'(proj), {THR_W{1'b0}}};
    if (adv_en) begin
      used_nxt = AMT_W'(usage_r[adv_h]);
      if (adv_budget == '0 || proj[BW] || XW'(proj) >= adv_budget) begin
        advice_nxt = ADV_DENY;
      end else if (proj_sh >= prod_c_r[adv_h]) begin
        advice_nxt = ADV_EVICT;
      end else if (proj_sh >= prod_w_r[adv_h]) begin
        advice_nxt = ADV_CAUTIOUS;
      end else begin
        advice_nxt = ADV_OK;
      end
    end

    // Device-local summary, taken after this word's update.
    usum     = (local_r[0] ? XW'(usage_nxt[0]) : '0) +
               (local_r[1] ? XW'(usage_nxt[1]) : '0);
    usum_sh  = {usum, {THR_W{1'b0}}};
    free_sum = '0;
    for (int h = 0; h < 2; h++) begin
      if (local_r[h] && XW'(budget_r[h]) > XW'(usage_nxt[h])) begin
        free_sum = free_sum + (XW'(budget_r[h]) - XW'(usage_nxt[h]));
      end
    end
    free_nxt = FREE_W'(free_sum);

    // With no device-local budget the ratio counts as zero.
    if (agg_zero_r) begin
      warn_nxt = (warn_r == '0);
      crit_nxt = (crit_r == '0);
    end else begin
      warn_nxt = (usum_sh >= agg_w_r);
      crit_nxt = (usum_sh >= agg_c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
      usage_r[0] <= '0;
      usage_r[1] <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
        usage_r   <= usage_nxt;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= opcode_t'(in_opcode);
      s1_sel_r <= in_heap_select;
      s1_amt_r <= in_byte_amount;
    end
    if (s1_go) begin
      out_advice            <= advice_nxt;
      out_usage_after       <= used_nxt;
      out_free_device_local <= free_nxt;
      out_local_warning     <= warn_nxt;
      out_local_critical    <= crit_nxt;
    end
  end

endmodule

// ===== rtl/hbm_checker.sv =====
// ----------------------------------------------------------------------------
// hbm_checker
// Port-level checks of the heap budget monitor, bound to the top level.
// ----------------------------------------------------------------------------
module hbm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_advice,
  input logic [hbm_pkg::AMT_W-1:0]   out_usage_after,
  input logic [hbm_pkg::FREE_W-1:0]  out_free_device_local,
  input logic                        out_local_warning,
  input logic                        out_local_critical
);
  import hbm_pkg::*;

  // A held result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_advice) &&
      $stable(out_usage_after) && $stable(out_free_device_local) &&
      $stable(out_local_warning) && $stable(out_local_critical))
    else $error("result word changed while stalled");

  // The input backs up only behind a stalled result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Every accepted word is expected to show up as a valid word in the result register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted word did not reach the output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind heap_budget_monitor hbm_checker u_hbm_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heap budget monitor. A usage tracker mirrors
// the heap counts and register settings, predicts the advice word for every
// accepted request and checks each result word in order. Directed requests
// cover saturation, flooring, out-of-range heaps, threshold boundaries and
// mask corner cases; random phases follow under varying back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import hbm_pkg::*;

  localparam logic [AMT_W-1:0]  BYTE_MAX  = {AMT_W{1'b1}};
  localparam logic [FREE_W-1:0] FREE_SAT  = {FREE_W{1'b1}};
  localparam logic [CIDX_W-1:0] CFG_NONE  = 3'd7;
  localparam int                CYCLE_CAP = 300000;

  typedef struct {
    advice_t           advice;
    logic [AMT_W-1:0]  usage_after;
    logic [FREE_W-1:0] free_local;
    logic              warn_flag;
    logic              crit_flag;
  } heap_report_t;

  class usage_tracker;
    logic [AMT_W-1:0] budget [2];
    logic [AMT_W-1:0] usage [2];
    logic [1:0]       local_mask;
    logic [1:0]       host_mask;
    logic [THR_W-1:0] warn_thr;
    logic [THR_W-1:0] crit_thr;
    heap_report_t     reports_due [$];
    int               errors;

    function new();
      budget[0]  = BUDGET0_RST;
      budget[1]  = BUDGET1_RST;
      usage[0]   = '0;
      usage[1]   = '0;
      local_mask = LOCAL_RST;
      host_mask  = 2'd2;
      warn_thr   = WARN_RST;
      crit_thr   = CRIT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
      case (idx)
        CFG_BUDGET0:   budget[0]  = val[AMT_W-1:0];
        CFG_BUDGET1:   budget[1]  = val[AMT_W-1:0];
        CFG_LOCAL_MSK: local_mask = val[1:0];
        CFG_HOST_MSK:  host_mask  = val[1:0];
        CFG_WARN_THR:  warn_thr   = val[THR_W-1:0];
        CFG_CRIT_THR:  crit_thr   = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // used / total >= thr / 2^16, done without division.
    function bit ratio_at_least(logic [63:0] used, logic [63:0] total, logic [THR_W-1:0] thr);
      return (used << 16) >= (total * {48'd0, thr});
    endfunction

    function advice_t advise_on(int h, logic [AMT_W-1:0] req);
      logic [63:0] b;
      logic [63:0] p;
      b = {24'd0, budget[h]};
      p = {24'd0, usage[h]} + {24'd0, req};
      if (b == 0 || p >= b) return ADV_DENY;
      if (ratio_at_least(p, b, crit_thr)) return ADV_EVICT;
      if (ratio_at_least(p, b, warn_thr)) return ADV_CAUTIOUS;
      return ADV_OK;
    endfunction

    function void note_request(opcode_t op, logic [1:0] sel, logic [AMT_W-1:0] amt);
      heap_report_t r;
      logic [63:0]  u;
      logic [63:0]  fsum;
      logic [63:0]  usum;
      logic [63:0]  bsum;
      r.advice      = ADV_OK;
      r.usage_after = '0;
      fsum = 0;
      usum = 0;
      bsum = 0;
      case (op) inside
        OP_ALLOC, OP_FREE: begin
          if (sel < 2) begin
            u = {24'd0, usage[sel[0]]};
            if (op == OP_ALLOC) begin
              u = u + {24'd0, amt};
              if (u > {24'd0, BYTE_MAX}) u = {24'd0, BYTE_MAX};
            end else begin
              u = (u >= {24'd0, amt}) ? u - {24'd0, amt} : 64'd0;
            end
            usage[sel[0]] = u[AMT_W-1:0];
            r.usage_after = u[AMT_W-1:0];
          end
        end
        OP_ADVISE: begin
          if (sel < 2) begin
            r.advice      = advise_on(int'(sel[0]), amt);
            r.usage_after = usage[sel[0]];
          end else begin
            r.advice = ADV_DENY;
          end
        end
        default: begin
          // The heap number is ignored: the lowest device-local heap answers.
          if (local_mask[0]) begin
            r.advice      = advise_on(0, amt);
            r.usage_after = usage[0];
          end else if (local_mask[1]) begin
            r.advice      = advise_on(1, amt);
            r.usage_after = usage[1];
          end else begin
            r.advice = ADV_DENY;
          end
        end
      endcase
      for (int h = 0; h < 2; h++) begin
        if (local_mask[h]) begin
          if (budget[h] > usage[h]) fsum = fsum + {24'd0, budget[h] - usage[h]};
          usum = usum + {24'd0, usage[h]};
          bsum = bsum + {24'd0, budget[h]};
        end
      end
      r.free_local = (fsum > {23'd0, FREE_SAT}) ? FREE_SAT : fsum[FREE_W-1:0];
      if (bsum == 0) begin
        r.warn_flag = (warn_thr == 0);
        r.crit_flag = (crit_thr == 0);
      end else begin
        r.warn_flag = ratio_at_least(usum, bsum, warn_thr);
        r.crit_flag = ratio_at_least(usum, bsum, crit_thr);
      end
      reports_due.push_back(r);
    endfunction

    function void check_report(logic [1:0] adv, logic [AMT_W-1:0] used,
                               logic [FREE_W-1:0] fdl, logic wf, logic cf);
      heap_report_t e;
      if (reports_due.size() == 0) begin
        $error("result word arrived with no request outstanding");
        errors++;
        return;
      end
      e = reports_due.pop_front();
      if (adv !== e.advice) begin
        $error("advice: expected %0d, got %0d", e.advice, adv);
        errors++;
      end
      if (used !== e.usage_after) begin
        $error("usage_after: expected %0d, got %0d", e.usage_after, used);
        errors++;
      end
      if (fdl !== e.free_local) begin
        $error("free_device_local: expected %0d, got %0d", e.free_local, fdl);
        errors++;
      end
      if (wf !== e.warn_flag) begin
        $error("local_warning: expected %0d, got %0d", e.warn_flag, wf);
        errors++;
      end
      if (cf !== e.crit_flag) begin
        $error("local_critical: expected %0d, got %0d", e.crit_flag, cf);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = '0;
  logic [1:0]        in_heap_select = '0;
  logic [AMT_W-1:0]  in_byte_amount = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_advice;
  logic [AMT_W-1:0]  out_usage_after;
  logic [FREE_W-1:0] out_free_device_local;
  logic              out_local_warning;
  logic              out_local_critical;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDAT_W-1:0] cfg_data = '0;

  usage_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  int cycle_count = 0;

  heap_budget_monitor uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_heap_select        (in_heap_select),
    .in_byte_amount        (in_byte_amount),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_advice            (out_advice),
    .out_usage_after       (out_usage_after),
    .out_free_device_local (out_free_device_local),
    .out_local_warning     (out_local_warning),
    .out_local_critical    (out_local_critical),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: a requested hold-off is counted down here, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.note_request(opcode_t'(in_opcode), in_heap_select, in_byte_amount);
    if (rst_n && out_valid && !out_stall)
      tracker.check_report(out_advice, out_usage_after, out_free_device_local,
                           out_local_warning, out_local_critical);
  end

  function automatic logic [AMT_W-1:0] rand_bytes();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[AMT_W-1:0];
  endfunction

  task automatic send_word(opcode_t op, logic [1:0] sel, logic [AMT_W-1:0] amt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid       <= 1'b0;
      in_opcode      <= 2'($urandom_range(3));
      in_heap_select <= 2'($urandom_range(3));
      in_byte_amount <= rand_bytes();
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_heap_select <= sel;
    in_byte_amount <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender pause: stop offering words until every result is back, then let
  // the pipeline empty before any register changes.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic end_config();
    cfg_valid <= 1'b0;
    cfg_data  <= rand_bytes();
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] pick_budget();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r < 3) return BYTE_MAX;
    if (r < 7) return rand_bytes();
    return AMT_W'($urandom_range(32'h0100_0000, 1024));
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return THR_W'($urandom_range(65535));
  endfunction

  task automatic random_config();
    write_reg(CFG_BUDGET0, pick_budget());
    write_reg(CFG_BUDGET1, pick_budget());
    write_reg(CFG_LOCAL_MSK,
              CDAT_W'(($urandom_range(9) == 0) ? 32'd0 : $urandom_range(3, 1)));
    write_reg(CFG_HOST_MSK, CDAT_W'($urandom_range(3)));
    write_reg(CFG_WARN_THR, CDAT_W'(pick_threshold()));
    write_reg(CFG_CRIT_THR, CDAT_W'(pick_threshold()));
    end_config();
  endtask

  // Amounts are mostly scaled to the selected heap's budget and usage so that
  // all four advice levels and both flags come up often.
  task automatic send_random();
    opcode_t          op;
    logic [1:0]       sel;
    logic [AMT_W-1:0] amt;
    logic [AMT_W-1:0] bud;
    logic [AMT_W-1:0] cur;
    logic [63:0]      t;
    int               r;
    int               h;
    r   = $urandom_range(99);
    op  = (r < 30) ? OP_ALLOC : (r < 50) ? OP_FREE : (r < 80) ? OP_ADVISE : OP_ADVISE_LOCAL;
    sel = 2'(($urandom_range(99) < 85) ? $urandom_range(1) : $urandom_range(3, 2));
    h   = (op == OP_ADVISE_LOCAL) ? (tracker.local_mask[0] ? 0 : 1) : int'(sel[0]);
    bud = tracker.budget[h];
    cur = tracker.usage[h];
    r   = $urandom_range(99);
    if (r < 8) amt = '0;
    else if (r < 13) amt = BYTE_MAX;
    else if (r < 28) amt = rand_bytes();
    else if (r < 36) amt = AMT_W'($urandom_range(4096));
    else begin
      case (op)
        OP_ALLOC: begin
          t   = ({24'd0, bud} * 64'($urandom_range(16384))) >> 16;
          amt = t[AMT_W-1:0];
        end
        OP_FREE: begin
          t   = ({24'd0, cur} * 64'($urandom_range(80000))) >> 16;
          amt = t[AMT_W-1:0];
        end
        default: begin
          t   = ({24'd0, bud} * 64'($urandom_range(72000))) >> 16;
          amt = (t[AMT_W-1:0] > cur) ? t[AMT_W-1:0] - cur : AMT_W'($urandom_range(255));
        end
      endcase
    end
    send_word(op, sel, amt);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: heap 0 budget 2^33, warning 0.8, critical 0.95.
    send_word(OP_ADVISE, 2'd0, 40'd4294967296);
    send_word(OP_ADVISE, 2'd0, 40'd8160411647);       // just under critical
    send_word(OP_ADVISE, 2'd0, 40'd8160411648);       // exactly critical
    send_word(OP_ADVISE, 2'd0, 40'd8589934592);       // projection equals budget
    send_word(OP_ALLOC, 2'd0, BYTE_MAX);
    send_word(OP_ALLOC, 2'd0, 40'd1);                 // stays saturated
    send_word(OP_ADVISE_LOCAL, 2'd3, '0);
    send_word(OP_FREE, 2'd0, BYTE_MAX - 40'd100);
    send_word(OP_FREE, 2'd0, 40'd1000);               // free more than held
    send_word(OP_ALLOC, 2'd0, 40'd6871973887);        // one byte below warning
    send_word(OP_ALLOC, 2'd0, 40'd1);                 // warning flag exactly
    send_word(OP_ALLOC, 2'd1, 40'd12884901888);
    send_word(OP_ADVISE, 2'd1, 40'd2147483648);
    send_word(OP_ALLOC, 2'd2, BYTE_MAX);
    send_word(OP_FREE, 2'd3, 40'd5);
    send_word(OP_ADVISE, 2'd2, '0);
    send_word(OP_ADVISE, 2'd3, BYTE_MAX);
    drain();

    // No device-local heap, zero warning threshold, unused register index.
    write_reg(CFG_LOCAL_MSK, CDAT_W'(2'd0));
    write_reg(CFG_HOST_MSK, CDAT_W'(2'd3));
    write_reg(CFG_WARN_THR, '0);
    write_reg(CFG_CRIT_THR, '1);
    write_reg(CFG_NONE, rand_bytes());
    end_config();
    send_word(OP_ADVISE_LOCAL, 2'd0, 40'd5);
    drain();

    // Zero budget on heap 0, critical threshold below warning on heap 1.
    write_reg(CFG_BUDGET0, '0);
    write_reg(CFG_BUDGET1, BYTE_MAX);
    write_reg(CFG_LOCAL_MSK, CDAT_W'(2'd2));
    write_reg(CFG_WARN_THR, CDAT_W'(16'd60000));
    write_reg(CFG_CRIT_THR, CDAT_W'(16'd1000));
    end_config();
    send_word(OP_ADVISE, 2'd0, '0);
    send_word(OP_ADVISE_LOCAL, 2'd1, 40'd549755813888);
    send_word(OP_ADVISE, 2'd1, 40'd1000);
    drain();

    // Both heaps device-local with the largest budgets.
    write_reg(CFG_BUDGET0, BYTE_MAX);
    write_reg(CFG_LOCAL_MSK, CDAT_W'(2'd3));
    write_reg(CFG_WARN_THR, '1);
    write_reg(CFG_CRIT_THR, '1);
    end_config();
    send_word(OP_FREE, 2'd0, BYTE_MAX);
    send_word(OP_FREE, 2'd1, BYTE_MAX);
    send_word(OP_ALLOC, 2'd1, BYTE_MAX);
    send_word(OP_ADVISE_LOCAL, 2'd2, 40'd1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 11 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        random_config();
        repeat (100) send_random();
      end
      if (ph == 2) begin
        // Long receiver hold-off while words keep coming.
        hold_off_left = 400;
        repeat (80) send_random();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.reports_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
